// ===== rtl/fdmc_pkg.sv =====
package fdmc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  // configuration reset values
  localparam logic [7:0] THRESHOLD_RESET = 8'd30;
  localparam logic [8:0] WIDTH_RESET     = 9'd320;
  localparam logic [7:0] HEIGHT_RESET    = 8'd240;

  // luma weights, sum is scaled by 256
  localparam logic [7:0] GRAY_R = 8'd77;
  localparam logic [7:0] GRAY_G = 8'd150;
  localparam logic [7:0] GRAY_B = 8'd29;

  // a frame reports motion above this many moving pixels
  localparam int unsigned MIN_MOVING = 100;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DIV
  } back_state_t;

endpackage

// ===== rtl/frame_difference_motion_centroid.sv =====
// path: a pixel waits in the decoupling queue, then in the working stage, and its result is registered at the output
// throughput: one pixel per cycle while out_stall is low; a frame end with detection
//   adds a centroid divide, one quotient bit a cycle, while later pixels wait in the queue
// reset: synchronous, clears control and accumulators, then a clearing pass
//   writes zero to all MAX_WIDTH*MAX_HEIGHT entries, one per cycle, with in_stall high
module frame_difference_motion_centroid #(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        pixel_is_rgb,
  input  logic [7:0]  gray_value,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        motion_bit,
  output logic        frame_end,
  output logic        detected,
  output logic [8:0]  centroid_x,
  output logic [7:0]  centroid_y,
  output logic [16:0] area
);
  import fdmc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EFF_W = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int EFF_H = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam int CNT_W = $clog2(EFF_W * EFF_H + 1);
  localparam int SX_W  = CNT_W + 9;
  localparam int SY_W  = CNT_W + 8;
  localparam int QW    = AW + 26;

  logic [7:0]    diff_threshold;
  logic [8:0]    line_pixels;
  logic [7:0]    frame_lines;
  logic          clearing;
  logic          q_full;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= THRESHOLD_RESET;
      line_pixels    <= WIDTH_RESET;
      frame_lines    <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: diff_threshold <= cfg_data[7:0];
        REG_WIDTH:     line_pixels    <= cfg_data;
        REG_HEIGHT:    frame_lines    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // pixel intake, gray conversion and addressing
  fdmc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_is_rgb(pixel_is_rgb),
    .gray_value  (gray_value),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .line_pixels (line_pixels),
    .frame_lines (frame_lines),
    .clearing    (clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  // decoupling queue
  fdmc_queue #(
    .W    (QW),
    .DEPTH(4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_data (q_head)
  );

  // frame compare, accumulation and report
  fdmc_back #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CNT_W(CNT_W),
    .SX_W (SX_W),
    .SY_W (SY_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .diff_threshold(diff_threshold),
    .q_valid       (q_valid),
    .q_data        (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .motion_bit    (motion_bit),
    .frame_end     (frame_end),
    .detected      (detected),
    .centroid_x    (centroid_x),
    .centroid_y    (centroid_y),
    .area          (area)
  );

endmodule

// ===== rtl/fdmc_ram.sv =====
module fdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 76800
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fdmc_queue.sv =====
module fdmc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entry[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !head_valid |-> !pop)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue level lost a transaction");
`endif

endmodule

// ===== rtl/fdmc_div.sv =====
module fdmc_div #(
  parameter int NW = 26,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num_x,
  input  logic [NW-1:0] num_y,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo_x,
  output logic [NW-1:0] quo_y
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_x;
  logic [DW-1:0] rem_y;
  logic [CW-1:0] steps;
  logic [DW:0]   try_x;
  logic [DW:0]   try_y;
  logic          fit_x;
  logic          fit_y;

  // one quotient bit of each division per cycle
  assign try_x = {rem_x, quo_x[NW-1]};
  assign try_y = {rem_y, quo_y[NW-1]};
  assign fit_x = (try_x >= {1'b0, den_q});
  assign fit_y = (try_y >= {1'b0, den_q});

  // restoring shift and subtract, both quotients share the step counter
  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      quo_x <= num_x;
      quo_y <= num_y;
      rem_x <= '0;
      rem_y <= '0;
    end else if (busy) begin
      rem_x <= fit_x ? DW'(try_x - {1'b0, den_q}) : try_x[DW-1:0];
      rem_y <= fit_y ? DW'(try_y - {1'b0, den_q}) : try_y[DW-1:0];
      quo_x <= {quo_x[NW-2:0], fit_x};
      quo_y <= {quo_y[NW-2:0], fit_y};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= CW'(NW);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/fdmc_front.sv =====
module fdmc_front #(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240,
  parameter int AW         = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pixel_is_rgb,
  input  logic [7:0]           gray_value,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic [8:0]           line_pixels,
  input  logic [7:0]           frame_lines,
  input  logic                 clearing,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [AW+25:0]       q_data
);
  import fdmc_pkg::*;

  localparam logic [8:0] W_CAP = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
  localparam logic [7:0] H_CAP = (MAX_HEIGHT > 255) ? 8'd255 : 8'(MAX_HEIGHT);

  logic [8:0]  column_count;
  logic [7:0]  row_count;
  logic [8:0]  w;
  logic [7:0]  h;
  logic [8:0]  col;
  logic [7:0]  row;
  logic        line_end;
  logic        last;
  logic [16:0] lin_addr;
  logic [15:0] luma_sum;
  logic [7:0]  gray;

  // clamp frame size to the storage
  always_comb begin
    if (line_pixels == '0) begin
      w = 9'd1;
    end else if (line_pixels > W_CAP) begin
      w = W_CAP;
    end else begin
      w = line_pixels;
    end
    if (frame_lines == '0) begin
      h = 8'd1;
    end else if (frame_lines > H_CAP) begin
      h = H_CAP;
    end else begin
      h = frame_lines;
    end
  end

  // position, saturated to the frame in use
  assign col      = (column_count < w) ? column_count : w - 1'b1;
  assign row      = (row_count < h) ? row_count : h - 1'b1;
  assign line_end = (col == w - 1'b1);
  assign last     = line_end && (row == h - 1'b1);
  assign lin_addr = 17'(row) * 17'(w) + 17'(col);

  // color to gray, or the gray input when pixel_is_rgb is low
  assign luma_sum = 16'(red) * 16'(GRAY_R) + 16'(green) * 16'(GRAY_G)
                  + 16'(blue) * 16'(GRAY_B);
  assign gray     = pixel_is_rgb ? luma_sum[15:8] : gray_value;

  assign in_stall = clearing || q_full;
  assign q_push   = in_valid && !in_stall;
  assign q_data   = {last, row, col, AW'(lin_addr), gray};

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (q_push) begin
      if (last) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (line_end) begin
        column_count <= '0;
        row_count    <= row + 1'b1;
      end else begin
        column_count <= col + 1'b1;
        row_count    <= row;
      end
    end
  end

endmodule

// ===== rtl/fdmc_back.sv =====
module fdmc_back #(
  parameter int DEPTH = 76800,
  parameter int AW    = 17,
  parameter int CNT_W = 17,
  parameter int SX_W  = 26,
  parameter int SY_W  = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     diff_threshold,
  input  logic           q_valid,
  input  logic [AW+25:0] q_data,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           motion_bit,
  output logic           frame_end,
  output logic           detected,
  output logic [8:0]     centroid_x,
  output logic [7:0]     centroid_y,
  output logic [16:0]    area
);
  import fdmc_pkg::*;

  back_state_t state, state_next;

  logic [AW-1:0]    clr_addr;
  logic             b1_valid;
  logic [7:0]       b1_gray;
  logic [AW-1:0]    b1_addr;
  logic [8:0]       b1_col;
  logic [7:0]       b1_row;
  logic             b1_last;
  logic             fwd_hit;
  logic [7:0]       fwd_data;
  logic [SX_W-1:0]  sum_of_x;
  logic [SY_W-1:0]  sum_of_y;
  logic [CNT_W-1:0] moving_count;

  logic [AW-1:0]    head_addr;
  logic [7:0]       ram_rdata;
  logic [7:0]       old;
  logic [7:0]       diff;
  logic             mv;
  logic [SX_W-1:0]  nx;
  logic [SY_W-1:0]  ny;
  logic [CNT_W-1:0] ncnt;
  logic             det;
  logic             out_free;
  logic             b_done;
  logic             div_start;
  logic             div_busy;
  logic [SX_W-1:0]  quo_x;
  logic [SX_W-1:0]  quo_y;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;

  assign head_addr = q_data[AW+7:8];
  assign clearing  = (state == ST_CLEAR);

  // previous frame store
  fdmc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (q_pop),
    .raddr(head_addr),
    .rdata(ram_rdata)
  );

  // centroid divider, started at a frame end with detection
  fdmc_div #(
    .NW(SX_W),
    .DW(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num_x(nx),
    .num_y(SX_W'(ny)),
    .den  (ncnt),
    .busy (div_busy),
    .quo_x(quo_x),
    .quo_y(quo_y)
  );

  // compare with stored pixel, forwarding the write of the previous pixel
  assign old  = fwd_hit ? fwd_data : ram_rdata;
  assign diff = (b1_gray >= old) ? b1_gray - old : old - b1_gray;
  assign mv   = (diff > diff_threshold);
  assign nx   = sum_of_x + (mv ? SX_W'(b1_col) : '0);
  assign ny   = sum_of_y + (mv ? SY_W'(b1_row) : '0);
  assign ncnt = moving_count + CNT_W'(mv);
  assign det  = (32'(ncnt) > MIN_MOVING);

  assign out_free = !out_valid || !out_stall;

  // sequencer
  always_comb begin
    state_next = state;
    b_done     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (b1_valid) begin
          if (b1_last && det) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else if (out_free) begin
            b_done = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          b_done     = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign q_pop     = q_valid && (state != ST_CLEAR) && (!b1_valid || b_done);
  assign ram_we    = clearing || b_done;
  assign ram_waddr = clearing ? clr_addr : b1_addr;
  assign ram_wdata = clearing ? 8'd0 : b1_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing sweep over the store
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // working stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (q_pop) begin
      b1_valid <= 1'b1;
    end else if (b_done) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_gray  <= q_data[7:0];
      b1_addr  <= head_addr;
      b1_col   <= q_data[AW+16:AW+8];
      b1_row   <= q_data[AW+24:AW+17];
      b1_last  <= q_data[AW+25];
      fwd_hit  <= b_done && (b1_addr == head_addr);
      fwd_data <= b1_gray;
    end
  end

  // motion accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_of_x     <= '0;
      sum_of_y     <= '0;
      moving_count <= '0;
    end else if (b_done) begin
      if (b1_last) begin
        sum_of_x     <= '0;
        sum_of_y     <= '0;
        moving_count <= '0;
      end else begin
        sum_of_x     <= nx;
        sum_of_y     <= ny;
        moving_count <= ncnt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_done) begin
      motion_bit <= mv;
      frame_end  <= b1_last;
      detected   <= b1_last && det;
      centroid_x <= (b1_last && det) ? quo_x[8:0] : 9'd0;
      centroid_y <= (b1_last && det) ? quo_y[7:0] : 8'd0;
      area       <= (b1_last && det) ? 17'(ncnt) : 17'd0;
    end
  end

`ifndef SYNTHESIS
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst) clearing |-> !out_valid)
    else $error("result issued during store clearing");
  a_div_holds_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (b1_valid && b1_last))
    else $error("divide without a frame end pixel");
  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !detected) |-> (centroid_x == '0 && centroid_y == '0 && area == '0))
    else $error("report fields set without detection");
`endif

endmodule
